// ----- design/pgcr_pkg.sv -----
// ----------------------------------------------------------------------------
// pgcr_pkg
// Shared types and constants of the pixel graph crossing resolver.
// ----------------------------------------------------------------------------
package pgcr_pkg;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int ISLAND_SCORE = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DONE,
    ST_RD_TL,
    ST_RD_TR,
    ST_RD_BL,
    ST_RD_BR,
    ST_EVAL,
    ST_WR_TL,
    ST_WR_TR,
    ST_WR_BL,
    ST_WR_BR,
    ST_STEP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;       // latch input word and clear window position
    logic       mem_rd;
    logic       mem_wr;
    logic [1:0] corner;     // 0 tl, 1 tr, 2 bl, 3 br
    logic       use_input;  // address from the input word
    logic       capture;    // keep read data for the given corner
    logic       eval;       // count the current window when it is crossed
    logic       step;       // advance window position
    logic       finish;     // drive result strobe
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    in_image;
    logic    crossed;
    logic    last_window;
  } stat_t;

  function automatic logic one_hot8(input logic [7:0] m);
    return (m != 8'd0) && ((m & (m - 8'd1)) == 8'd0);
  endfunction

endpackage

// ----- design/pgcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// pgcr_ctrl
// Sequencer for write, read and the resolve window walk.
// ----------------------------------------------------------------------------
module pgcr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pgcr_pkg::stat_t  stat,
  output pgcr_pkg::ctrl_t  ctrl
);

  pgcr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgcr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pgcr_pkg::ST_IDLE: begin
        if (start) state_next = pgcr_pkg::ST_WRITE;
      end
      pgcr_pkg::ST_WRITE: begin
        case (stat.op)
          pgcr_pkg::OP_WRITE:   state_next = pgcr_pkg::ST_DONE;
          pgcr_pkg::OP_READ:    state_next = pgcr_pkg::ST_READ;
          pgcr_pkg::OP_RESOLVE: state_next = pgcr_pkg::ST_RD_TL;
          default:              state_next = pgcr_pkg::ST_DONE;
        endcase
      end
      pgcr_pkg::ST_READ:  state_next = pgcr_pkg::ST_DONE;
      pgcr_pkg::ST_DONE:  state_next = pgcr_pkg::ST_IDLE;
      pgcr_pkg::ST_RD_TL: state_next = pgcr_pkg::ST_RD_TR;
      pgcr_pkg::ST_RD_TR: state_next = pgcr_pkg::ST_RD_BL;
      pgcr_pkg::ST_RD_BL: state_next = pgcr_pkg::ST_RD_BR;
      pgcr_pkg::ST_RD_BR: state_next = pgcr_pkg::ST_EVAL;
      pgcr_pkg::ST_EVAL: begin
        state_next = stat.crossed ? pgcr_pkg::ST_WR_TL : pgcr_pkg::ST_STEP;
      end
      pgcr_pkg::ST_WR_TL: state_next = pgcr_pkg::ST_WR_TR;
      pgcr_pkg::ST_WR_TR: state_next = pgcr_pkg::ST_WR_BL;
      pgcr_pkg::ST_WR_BL: state_next = pgcr_pkg::ST_WR_BR;
      pgcr_pkg::ST_WR_BR: state_next = pgcr_pkg::ST_STEP;
      pgcr_pkg::ST_STEP: begin
        state_next = stat.last_window ? pgcr_pkg::ST_DONE : pgcr_pkg::ST_RD_TL;
      end
      default: state_next = pgcr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = (state != pgcr_pkg::ST_IDLE);
    case (state)
      pgcr_pkg::ST_IDLE: begin
        ctrl.load = start;
      end
      pgcr_pkg::ST_WRITE: begin
        ctrl.use_input = 1'b1;
        ctrl.mem_wr = (stat.op == pgcr_pkg::OP_WRITE) && stat.in_image;
        ctrl.mem_rd = (stat.op == pgcr_pkg::OP_READ);
      end
      pgcr_pkg::ST_READ: begin
        ctrl.use_input = 1'b1;
        ctrl.capture = 1'b1;
      end
      pgcr_pkg::ST_DONE: ctrl.finish = 1'b1;
      pgcr_pkg::ST_RD_TL: begin
        ctrl.mem_rd = 1'b1;
        ctrl.corner = 2'd0;
      end
      pgcr_pkg::ST_RD_TR: begin
        ctrl.mem_rd = 1'b1;
        ctrl.corner = 2'd1;
        ctrl.capture = 1'b1;
      end
      pgcr_pkg::ST_RD_BL: begin
        ctrl.mem_rd = 1'b1;
        ctrl.corner = 2'd2;
        ctrl.capture = 1'b1;
      end
      pgcr_pkg::ST_RD_BR: begin
        ctrl.mem_rd = 1'b1;
        ctrl.corner = 2'd3;
        ctrl.capture = 1'b1;
      end
      pgcr_pkg::ST_EVAL: begin
        ctrl.corner = 2'd3;
        ctrl.capture = 1'b1;
        ctrl.eval = 1'b1;
      end
      pgcr_pkg::ST_WR_TL: begin
        ctrl.mem_wr = 1'b1;
        ctrl.corner = 2'd0;
      end
      pgcr_pkg::ST_WR_TR: begin
        ctrl.mem_wr = 1'b1;
        ctrl.corner = 2'd1;
      end
      pgcr_pkg::ST_WR_BL: begin
        ctrl.mem_wr = 1'b1;
        ctrl.corner = 2'd2;
      end
      pgcr_pkg::ST_WR_BR: begin
        ctrl.mem_wr = 1'b1;
        ctrl.corner = 2'd3;
      end
      pgcr_pkg::ST_STEP: ctrl.step = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |=> !ctrl.finish)
    else $error("result strobe repeated");
  a_start_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == pgcr_pkg::ST_WRITE))
    else $error("accepted word not taken");
  a_no_rw: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.mem_rd && ctrl.mem_wr))
    else $error("read and write together");
`endif

endmodule

// ----- design/pgcr_dp.sv -----
// ----------------------------------------------------------------------------
// pgcr_dp
// Link mask memory, window registers, cut decision and result registers.
// ----------------------------------------------------------------------------
module pgcr_dp #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  pgcr_pkg::ctrl_t ctrl,
  output pgcr_pkg::stat_t stat,
  input  logic [1:0]      opcode,
  input  logic [5:0]      column,
  input  logic [5:0]      row,
  input  logic [7:0]      link_mask_in,
  input  logic            cfg_wr,
  input  logic            cfg_index,
  input  logic [6:0]      cfg_data,
  output logic            done,
  output logic [7:0]      link_mask_out,
  output logic [12:0]     diagonals_cut
);

  localparam int CW = (MAX_COLUMNS > 64) ? $clog2(MAX_COLUMNS) : 6;
  localparam int RW = (MAX_ROWS > 64) ? $clog2(MAX_ROWS) : 6;
  localparam int XB = $clog2(MAX_COLUMNS);
  localparam int YB = $clog2(MAX_ROWS);
  localparam int AW = XB + YB;
  localparam int DEPTH = 1 << AW;

  logic [6:0] width_reg, height_reg;
  logic [CW:0] w_eff;
  logic [RW:0] h_eff;
  pgcr_pkg::opcode_t op_r;
  logic [5:0] col_r, row_r;
  logic [7:0] mask_r;
  logic [XB-1:0] wx;
  logic [YB-1:0] wy;
  logic [12:0] count;
  logic [7:0] tl, tr, bl, br;
  logic [7:0] tl_c, tr_c, bl_c, br_c;
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata;
  logic [1:0] rd_corner;
  logic in_image;
  logic [7:0] wmask;
  logic [XB-1:0] ax;
  logic [YB-1:0] ay;
  logic [AW-1:0] addr;
  logic [7:0] wdata;
  logic [3:0] wt_pos, wt_neg;
  logic boxed, crossed, cut_a, cut_b;
  logic wy_last, last_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 7'd64;
      height_reg <= 7'd64;
    end else if (cfg_wr) begin
      if (cfg_index == pgcr_pkg::CFG_WIDTH) width_reg <= cfg_data;
      else height_reg <= cfg_data;
    end
  end

  always_comb begin
    if (width_reg < 7'd2) w_eff = (CW+1)'(2);
    else if ((CW+1)'(width_reg) > (CW+1)'(MAX_COLUMNS)) w_eff = (CW+1)'(MAX_COLUMNS);
    else w_eff = (CW+1)'(width_reg);
    if (height_reg < 7'd2) h_eff = (RW+1)'(2);
    else if ((RW+1)'(height_reg) > (RW+1)'(MAX_ROWS)) h_eff = (RW+1)'(MAX_ROWS);
    else h_eff = (RW+1)'(height_reg);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r   <= pgcr_pkg::opcode_t'(opcode);
      col_r  <= column;
      row_r  <= row;
      mask_r <= link_mask_in;
    end
  end

  assign in_image = ((CW+1)'(col_r) < w_eff) && ((RW+1)'(row_r) < h_eff);

  always_comb begin
    wmask = mask_r;
    if (col_r == 6'd0) wmask = wmask & ~8'h29;
    if ((CW+1)'(col_r) == w_eff - (CW+1)'(1)) wmask = wmask & ~8'h94;
    if (row_r == 6'd0) wmask = wmask & ~8'h07;
    if ((RW+1)'(row_r) == h_eff - (RW+1)'(1)) wmask = wmask & ~8'hE0;
  end

  assign boxed = tl[4] && tl[6] && tr[6] && bl[4];
  assign wt_pos = (pgcr_pkg::one_hot8(tl) ? 4'(pgcr_pkg::ISLAND_SCORE) : 4'd0)
                + (pgcr_pkg::one_hot8(br) ? 4'(pgcr_pkg::ISLAND_SCORE) : 4'd0);
  assign wt_neg = (pgcr_pkg::one_hot8(tr) ? 4'(pgcr_pkg::ISLAND_SCORE) : 4'd0)
                + (pgcr_pkg::one_hot8(bl) ? 4'(pgcr_pkg::ISLAND_SCORE) : 4'd0);
  assign crossed = tl[7] && tr[5];

  // tl/br diagonal on a negative weight, tr/bl otherwise, both when boxed
  always_comb begin
    cut_a = boxed || (wt_pos < wt_neg);
    cut_b = boxed || !(wt_pos < wt_neg);
  end

  assign tl_c = cut_a ? (tl & ~8'h80) : tl;
  assign br_c = cut_a ? (br & ~8'h01) : br;
  assign tr_c = cut_b ? (tr & ~8'h20) : tr;
  assign bl_c = cut_b ? (bl & ~8'h04) : bl;

  always_comb begin
    if (ctrl.use_input) begin
      ax = XB'(col_r);
      ay = YB'(row_r);
    end else begin
      ax = wx + XB'(ctrl.corner[0]);
      ay = wy + YB'(ctrl.corner[1]);
    end
    addr = {ax, ay};
    case (ctrl.corner)
      2'd0: wdata = tl_c;
      2'd1: wdata = tr_c;
      2'd2: wdata = bl_c;
      default: wdata = br_c;
    endcase
    if (ctrl.use_input) wdata = wmask;
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_wr) mem[addr] <= wdata;
    if (ctrl.mem_rd) rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_rd) rd_corner <= ctrl.corner;
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture && !ctrl.use_input) begin
      case (rd_corner)
        2'd0: tl <= rdata;
        2'd1: tr <= rdata;
        2'd2: bl <= rdata;
        default: br <= rdata;
      endcase
    end
  end

  assign wy_last = ((RW+1)'(wy) == h_eff - (RW+1)'(2));
  assign last_window = ((CW+1)'(wx) == w_eff - (CW+1)'(2)) && wy_last;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      wx <= '0;
      wy <= '0;
      count <= '0;
    end else begin
      if (ctrl.step) begin
        if (wy_last) begin
          wy <= '0;
          wx <= wx + XB'(1);
        end else begin
          wy <= wy + YB'(1);
        end
      end
      if (ctrl.eval && crossed) count <= count + 13'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      link_mask_out <= '0;
      diagonals_cut <= '0;
    end else begin
      done <= ctrl.finish;
      if (ctrl.finish) begin
        link_mask_out <= (op_r == pgcr_pkg::OP_READ && in_image) ? rdata : 8'd0;
        diagonals_cut <= (op_r == pgcr_pkg::OP_RESOLVE) ? count : 13'd0;
      end
    end
  end

  assign stat.op = op_r;
  assign stat.in_image = in_image;
  assign stat.crossed = crossed;
  assign stat.last_window = last_window;

endmodule

// ----- design/pixel_graph_crossing_resolver.sv -----
// ----------------------------------------------------------------------------
// pixel_graph_crossing_resolver
// Per-pixel link mask store with diagonal crossing resolution.
// ----------------------------------------------------------------------------
// usage:
//   command channel: a word is taken when start is high and busy is low
//   result: done pulses one cycle with link_mask_out and diagonals_cut
//   config: cfg_valid/cfg_ready with cfg_index and cfg_data; ready always
//   write and unused words: the WRITE state, then DONE, then done is registered
//   read words: WRITE, READ and DONE in turn, then done is registered
//   resolve: WRITE, then per 2x2 window 4 reads, evaluate and advance, with 4
//   writes more when crossed, all through the single memory port, then DONE
//   busy drops in the done cycle, so the next word can be taken there
//   reset: width and height return to 64, the mask memory is not cleared
//   the receiver cannot stall: the result is valid for the done cycle only
// ----------------------------------------------------------------------------
module pixel_graph_crossing_resolver #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [5:0]  column,
  input  logic [5:0]  row,
  input  logic [7:0]  link_mask_in,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        done,
  output logic [7:0]  link_mask_out,
  output logic [12:0] diagonals_cut
);

  pgcr_pkg::ctrl_t ctrl;
  pgcr_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  pgcr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .ctrl (ctrl)
  );

  pgcr_dp #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .opcode       (opcode),
    .column       (column),
    .row          (row),
    .link_mask_in (link_mask_in),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .link_mask_out(link_mask_out),
    .diagonals_cut(diagonals_cut)
  );

endmodule

// ----- bench/pgcr_checker.sv -----
// ----------------------------------------------------------------------------
// pgcr_checker
// Watches the command, config and result channels of the crossing resolver,
// keeps its own copy of the link mask memory and image size, predicts each
// result word and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module pgcr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  opcode,
  input  logic [5:0]  column,
  input  logic [5:0]  row,
  input  logic [7:0]  link_mask_in,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        done,
  input  logic [7:0]  link_mask_out,
  input  logic [12:0] diagonals_cut,
  output int          fail_count,
  output int          pending,
  output int          words_checked,
  output int          windows_cut
);

  typedef struct {
    logic [7:0]  mask;
    logic [12:0] cut;
  } outcome_t;

  logic [7:0] mask_mem [0:4095];
  logic [6:0] width_reg, height_reg;
  outcome_t   outcomes_due [$];

  function automatic int clamp_dim(logic [6:0] v);
    if (v < 2) return 2;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  function automatic logic [12:0] resolve_windows();
    int w, h, n;
    int tl, tr, bl, br;
    int weight;
    logic boxed;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    n = 0;
    for (int x = 0; x + 1 < w; x++) begin
      for (int y = 0; y + 1 < h; y++) begin
        tl = x * 64 + y;
        tr = (x + 1) * 64 + y;
        bl = x * 64 + y + 1;
        br = (x + 1) * 64 + y + 1;
        if (!mask_mem[tl][7] || !mask_mem[tr][5]) continue;
        boxed = mask_mem[tl][4] && mask_mem[tl][6]
             && mask_mem[tr][6] && mask_mem[bl][4];
        if (boxed) begin
          mask_mem[tl][7] = 1'b0;
          mask_mem[br][0] = 1'b0;
          mask_mem[tr][5] = 1'b0;
          mask_mem[bl][2] = 1'b0;
        end else begin
          weight = ($countones(mask_mem[tl]) == 1 ? pgcr_pkg::ISLAND_SCORE : 0)
                 + ($countones(mask_mem[br]) == 1 ? pgcr_pkg::ISLAND_SCORE : 0)
                 - ($countones(mask_mem[tr]) == 1 ? pgcr_pkg::ISLAND_SCORE : 0)
                 - ($countones(mask_mem[bl]) == 1 ? pgcr_pkg::ISLAND_SCORE : 0);
          if (weight < 0) begin
            mask_mem[tl][7] = 1'b0;
            mask_mem[br][0] = 1'b0;
          end else begin
            mask_mem[tr][5] = 1'b0;
            mask_mem[bl][2] = 1'b0;
          end
        end
        n++;
      end
    end
    return n[12:0];
  endfunction

  function automatic outcome_t predict_word(pgcr_pkg::opcode_t op, int x, int y,
                                            logic [7:0] m);
    outcome_t o;
    int w, h;
    logic in_image;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    in_image = (x < w) && (y < h);
    o.mask = 8'd0;
    o.cut = 13'd0;
    case (op)
      pgcr_pkg::OP_WRITE: begin
        if (in_image) begin
          if (x == 0) m &= ~8'h29;
          if (x == w - 1) m &= ~8'h94;
          if (y == 0) m &= ~8'h07;
          if (y == h - 1) m &= ~8'hE0;
          mask_mem[x * 64 + y] = m;
        end
      end
      pgcr_pkg::OP_RESOLVE: o.cut = resolve_windows();
      pgcr_pkg::OP_READ: if (in_image) o.mask = mask_mem[x * 64 + y];
      default: ;
    endcase
    return o;
  endfunction

  initial begin
    fail_count = 0;
    words_checked = 0;
    windows_cut = 0;
    pending = 0;
    width_reg = 7'd64;
    height_reg = 7'd64;
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      outcomes_due.delete();
      width_reg <= 7'd64;
      height_reg <= 7'd64;
    end else begin
      if (done) begin
        if (outcomes_due.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = outcomes_due.pop_front();
          if (link_mask_out !== want.mask) begin
            $error("link_mask_out expected %0h got %0h", want.mask, link_mask_out);
            fail_count++;
          end
          if (diagonals_cut !== want.cut) begin
            $error("diagonals_cut expected %0d got %0d", want.cut, diagonals_cut);
            fail_count++;
          end
          windows_cut += int'(want.cut);
          words_checked++;
        end
      end
      if (start && !busy)
        outcomes_due.push_back(predict_word(pgcr_pkg::opcode_t'(opcode), int'(column),
                                            int'(row), link_mask_in));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pgcr_pkg::CFG_WIDTH) width_reg <= cfg_data;
        else height_reg <= cfg_data;
      end
    end
    pending <= outcomes_due.size();
  end

endmodule

// ----- bench/tb_pixel_graph_crossing_resolver.sv -----
// ----------------------------------------------------------------------------
// tb_pixel_graph_crossing_resolver
// Drives the crossing resolver through a series of image sizes, including the
// clamped extremes. Small sizes fill every pixel first; the full-size run
// reads only pixels it has written. Random writes, reads, resolves and unused
// opcodes follow with random gaps; a checker beside the block predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module tb_pixel_graph_crossing_resolver;

  localparam int LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = '0;
  logic [5:0]  column = '0;
  logic [5:0]  row = '0;
  logic [7:0]  link_mask_in = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;
  logic        done;
  logic [7:0]  link_mask_out;
  logic [12:0] diagonals_cut;
  int          fail_count, pending, words_checked, windows_cut;
  int          cycles = 0;
  int          eff_w = 64, eff_h = 64;
  int          sizes_run = 0;
  bit          written [4096];

  pixel_graph_crossing_resolver uut (.*);
  pgcr_checker chk (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    repeat (n) @(negedge clk);
  endtask

  task automatic issue(pgcr_pkg::opcode_t op, int x, int y, logic [7:0] m);
    opcode = op;
    column = x[5:0];
    row = y[5:0];
    link_mask_in = m;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    start = 1'b0;
    if (op == pgcr_pkg::OP_WRITE && x < eff_w && y < eff_h) written[x * 64 + y] = 1'b1;
    idle_gap();
  endtask

  task automatic set_reg(logic idx, logic [6:0] v);
    while (pending != 0 || start) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == pgcr_pkg::CFG_WIDTH) eff_w = v < 2 ? 2 : (v > 64 ? 64 : v);
    else eff_h = v < 2 ? 2 : (v > 64 ? 64 : v);
  endtask

  function automatic logic [7:0] rand_mask();
    case ($urandom_range(0, 3))
      0: return 8'($urandom);
      1: return 8'h01 << $urandom_range(0, 7);
      default: return 8'($urandom) | 8'hA0;
    endcase
  endfunction

  function automatic bit all_written();
    for (int x = 0; x < eff_w; x++)
      for (int y = 0; y < eff_h; y++)
        if (!written[x * 64 + y]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic fill_image();
    for (int x = 0; x < eff_w; x++)
      for (int y = 0; y < eff_h; y++)
        issue(pgcr_pkg::OP_WRITE, x, y, rand_mask());
  endtask

  task automatic run_size(logic [6:0] w, logic [6:0] h, int words, bit do_fill);
    int x, y, sel, resolves;
    pgcr_pkg::opcode_t op;
    resolves = 0;
    set_reg(pgcr_pkg::CFG_WIDTH, w);
    set_reg(pgcr_pkg::CFG_HEIGHT, h);
    if (do_fill) fill_image();
    sizes_run++;
    for (int i = 0; i < words; i++) begin
      x = $urandom_range(0, eff_w - 1);
      y = $urandom_range(0, eff_h - 1);
      sel = $urandom_range(0, 99);
      if (sel >= 90) begin
        if (eff_w < 64) x = $urandom_range(eff_w, 63);
        else if (eff_h < 64) y = $urandom_range(eff_h, 63);
      end
      if (sel < 40 || sel >= 90)
        op = $urandom_range(0, 1) ? pgcr_pkg::OP_WRITE : pgcr_pkg::OP_READ;
      else if (sel < 75)
        op = pgcr_pkg::OP_READ;
      else if (sel < 85)
        op = pgcr_pkg::OP_RESOLVE;
      else
        op = pgcr_pkg::OP_NONE;
      if (op == pgcr_pkg::OP_RESOLVE &&
          !(all_written() && (eff_w * eff_h <= 1024 || resolves < 2)))
        op = pgcr_pkg::OP_READ;
      if (op == pgcr_pkg::OP_READ && x < eff_w && y < eff_h && !written[x * 64 + y])
        op = pgcr_pkg::OP_WRITE;
      if (op == pgcr_pkg::OP_RESOLVE) resolves++;
      issue(op, x, y, rand_mask());
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: 2x2 image from clamped sizes, all-ones masks, boxed crossing
    set_reg(pgcr_pkg::CFG_WIDTH, 7'd0);
    set_reg(pgcr_pkg::CFG_HEIGHT, 7'd1);
    issue(pgcr_pkg::OP_WRITE, 0, 0, 8'hFF);
    issue(pgcr_pkg::OP_WRITE, 1, 0, 8'hFF);
    issue(pgcr_pkg::OP_WRITE, 0, 1, 8'hFF);
    issue(pgcr_pkg::OP_WRITE, 1, 1, 8'hFF);
    for (int i = 0; i < 4; i++) issue(pgcr_pkg::OP_READ, i % 2, i / 2, 8'h00);
    issue(pgcr_pkg::OP_RESOLVE, 0, 0, 8'h00);
    for (int i = 0; i < 4; i++) issue(pgcr_pkg::OP_READ, i % 2, i / 2, 8'h00);
    issue(pgcr_pkg::OP_RESOLVE, 63, 63, 8'hFF);
    issue(pgcr_pkg::OP_NONE, 63, 63, 8'hFF);
    issue(pgcr_pkg::OP_WRITE, 63, 0, 8'hFF);
    issue(pgcr_pkg::OP_READ, 63, 63, 8'h00);
    issue(pgcr_pkg::OP_READ, 0, 63, 8'h00);
    // island case: a lone link in every corner, so the weights tie
    issue(pgcr_pkg::OP_WRITE, 0, 0, 8'h80);
    issue(pgcr_pkg::OP_WRITE, 1, 0, 8'h20);
    issue(pgcr_pkg::OP_WRITE, 0, 1, 8'h04);
    issue(pgcr_pkg::OP_WRITE, 1, 1, 8'h01);
    issue(pgcr_pkg::OP_RESOLVE, 0, 0, 8'h00);
    for (int i = 0; i < 4; i++) issue(pgcr_pkg::OP_READ, i % 2, i / 2, 8'h00);

    run_size(7'd127, 7'd127, 40, 1'b0);
    run_size(7'd2, 7'd40, 25, 1'b1);
    run_size(7'd65, 7'd2, 20, 1'b1);
    for (int p = 0; p < 4; p++)
      run_size(7'($urandom_range(2, 6)), 7'($urandom_range(2, 6)), 10, 1'b1);

    while (pending != 0 && cycles < LIMIT) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("covered %0d image sizes, %0d result words, %0d crossings resolved",
             sizes_run + 1, words_checked, windows_cut);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
